>>> sv/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

  localparam int CODE_W   = 5;
  localparam int SQ_SIDE  = 5;
  localparam int SQ_CELLS = SQ_SIDE * SQ_SIDE;
  localparam int SQ_W     = SQ_CELLS * CODE_W;
  localparam int HALF_W   = 2 * SQ_SIDE * CODE_W;
  localparam int ROW_W    = SQ_SIDE * CODE_W;

  typedef logic [CODE_W-1:0] letter_t;
  typedef logic [2:0]        coord_t;
  typedef logic [4:0]        cell_idx_t;
  typedef logic [SQ_W-1:0]   square_t;
  typedef logic [SQ_CELLS-1:0] match_t;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_X = letter_t'(23);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS_01 = 2'd0,
    REG_ROWS_23 = 2'd1,
    REG_ROW_4   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  // Stage advance strobes shared between top level and locator
  typedef struct packed {
    logic cmp;
    logic enc;
  } adv_t;

  // Located position of one letter
  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
  } loc_t;

  // Equal codes match, and I matches J
  function automatic logic letters_match(letter_t a, letter_t b);
    logic m;
    m = (a == b) ||
        ((a == LETTER_I) && (b == LETTER_J)) ||
        ((a == LETTER_J) && (b == LETTER_I));
    return m;
  endfunction

  // Step one place along a row or column with wrap
  function automatic coord_t wrap_inc(coord_t c);
    coord_t n;
    n = (c == coord_t'(SQ_SIDE - 1)) ? coord_t'(0) : coord_t'(c + coord_t'(1));
    return n;
  endfunction

  // Row-major cell index: row * 5 + col
  function automatic cell_idx_t cell_index(coord_t row, coord_t col);
    cell_idx_t idx;
    idx = cell_idx_t'({row, 2'b00}) + cell_idx_t'(row) + cell_idx_t'(col);
    return idx;
  endfunction

  // Letter code stored at one cell of the square
  function automatic letter_t cell_code(square_t sq, cell_idx_t idx);
    letter_t code;
    code = '0;
    for (int p = 0; p < SQ_CELLS; p++) begin
      if (idx == cell_idx_t'(p)) begin
        code = sq[p*CODE_W +: CODE_W];
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> sv/pfe_locate.sv
`default_nettype none

module pfe_locate (
  input  wire logic            clk,
  input  wire pfe_pkg::adv_t   adv,
  input  wire pfe_pkg::letter_t letter,
  input  wire pfe_pkg::square_t square,
  output pfe_pkg::loc_t        loc
);
  import pfe_pkg::*;

  match_t match;
  match_t match_next;
  loc_t   loc_next;

  // Compare the letter against every cell
  always_comb begin
    for (int p = 0; p < SQ_CELLS; p++) begin
      match_next[p] = letters_match(letter, square[p*CODE_W +: CODE_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.cmp) begin
      match <= match_next;
    end
  end

  // Take the first matching cell in row-major order
  always_comb begin
    loc_next = '0;
    for (int r = SQ_SIDE - 1; r >= 0; r--) begin
      for (int c = SQ_SIDE - 1; c >= 0; c--) begin
        if (match[r*SQ_SIDE + c]) begin
          loc_next.found = 1'b1;
          loc_next.row   = coord_t'(r);
          loc_next.col   = coord_t'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.enc) begin
      loc <= loc_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/playfair_pair_encrypt_top.sv
// Playfair digraph encryptor.
//
// Input channel s_*: one letter pair per item. s_tdata holds first_letter
// in bits [4:0] and second_letter in [9:5]; s_tuser is pad_second, which
// replaces the second letter with X. Output channel m_*: one result per
// item, m_tdata holds cipher_first [4:0] and cipher_second [9:5], m_tuser
// is not_found (both letters then read zero).
// The key square is written through cfg_*: index 0 loads rows 0-1, index 1
// rows 2-3, index 2 row 4, five bits per cell with cell 0 lowest. Write it
// only while no item is in flight; cfg_ready is always high.
//
// Four register stages: cell compare, first-match encode, rule select,
// cell fetch. An accepted item passes these stages in that order and is
// offered on m_* from cell fetch; one item is taken every cycle while
// m_tready stays high. When the receiver stalls, the stages fill up behind
// the output register and s_tready drops only once all four stages hold
// an item; nothing is lost or repeated. Reset clears all valid bits and
// the key square to zero.
`default_nettype none

module playfair_pair_encrypt_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // first_letter, second_letter, zero fill
  input  wire logic        s_tuser,   // pad_second
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // cipher_first, cipher_second, zero fill
  output      logic        m_tuser,   // not_found
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [49:0] cfg_data
);
  import pfe_pkg::*;

  logic [HALF_W-1:0] key_rows_zero_one;
  logic [HALF_W-1:0] key_rows_two_three;
  logic [ROW_W-1:0]  key_row_four;
  square_t           square;

  logic    v1, v2, v3, v4;
  logic    rdy1, rdy2, rdy3, rdy4;
  adv_t    adv;
  letter_t first_in;
  letter_t second_in;
  loc_t    loc_a;
  loc_t    loc_b;

  cell_idx_t idx_a;
  cell_idx_t idx_b;
  cell_idx_t idx_a_next;
  cell_idx_t idx_b_next;
  logic      miss;
  letter_t   out_first;
  letter_t   out_second;
  logic      out_miss;

  // Hold the key square
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows_zero_one  <= '0;
      key_rows_two_three <= '0;
      key_row_four       <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROWS_01: key_rows_zero_one  <= cfg_data[HALF_W-1:0];
        REG_ROWS_23: key_rows_two_three <= cfg_data[HALF_W-1:0];
        REG_ROW_4:   key_row_four       <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign square = {key_row_four, key_rows_two_three, key_rows_zero_one};

  // Advance each stage when the one after it can take its item
  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign adv.cmp  = s_tvalid && rdy1;
  assign adv.enc  = v1 && rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Substitute X for a padded tail
  assign first_in  = s_tdata[CODE_W-1:0];
  assign second_in = s_tuser ? LETTER_X : s_tdata[2*CODE_W-1:CODE_W];

  pfe_locate u_loc_a (
    .clk    (clk),
    .adv    (adv),
    .letter (first_in),
    .square (square),
    .loc    (loc_a)
  );

  pfe_locate u_loc_b (
    .clk    (clk),
    .adv    (adv),
    .letter (second_in),
    .square (square),
    .loc    (loc_b)
  );

  // Apply the row, column or rectangle rule
  always_comb begin
    if (loc_a.row == loc_b.row) begin
      idx_a_next = cell_index(loc_a.row, wrap_inc(loc_a.col));
      idx_b_next = cell_index(loc_b.row, wrap_inc(loc_b.col));
    end else if (loc_a.col == loc_b.col) begin
      idx_a_next = cell_index(wrap_inc(loc_a.row), loc_a.col);
      idx_b_next = cell_index(wrap_inc(loc_b.row), loc_b.col);
    end else begin
      idx_a_next = cell_index(loc_a.row, loc_b.col);
      idx_b_next = cell_index(loc_b.row, loc_a.col);
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
      miss  <= !(loc_a.found && loc_b.found);
    end
  end

  // Fetch the cipher letters, zero on a miss
  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      out_first  <= miss ? letter_t'(0) : cell_code(square, idx_a);
      out_second <= miss ? letter_t'(0) : cell_code(square, idx_b);
      out_miss   <= miss;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {6'b0, out_second, out_first};
  assign m_tuser  = out_miss;

endmodule

`default_nettype wire

>>> sv/pfe_checker.sv
`default_nettype none

module pfe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A miss carries zero letters
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 16'h0000))
    else $error("miss with nonzero letters");

  // Input backpressure only while the output is stalled
  a_bp_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output stall");

  // Nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind playfair_pair_encrypt_top pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

`default_nettype wire

>>> test/tb_playfair_pair_encrypt_top.sv
`timescale 1ns / 1ps

module tb_playfair_pair_encrypt_top;
  import pfe_pkg::*;

  localparam int PIPE_DRAIN  = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_PHASES = 8;
  localparam int PAIRS_PER_PHASE = 144;

  // Squares used by the directed rows
  typedef enum logic [1:0] {
    KEY_ZERO,
    KEY_CLASSIC,
    KEY_ONES
  } key_pick_t;

  // Ways of filling a random square
  typedef enum logic [1:0] {
    MIX_PERMUTED,
    MIX_SCATTERED,
    MIX_PARTIAL,
    MIX_CROWDED
  } square_mix_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    not_found;
  } cipher_t;

  typedef struct packed {
    key_pick_t key;
    letter_t   first;
    letter_t   second;
    logic      pad;
    logic      typed;
    cipher_t   res;
  } pair_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_idx_t    cfg_index;
  logic [49:0] cfg_data;

  square_t     key_sq = '0;
  cipher_t     cipher_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  string       classic_key = "PLAYFIREXMBCDGHKNOQSTUVWZ";

  // Directed pairs; typed rows carry their result, the rest go through the predictor
  pair_row_t dir_rows [22] = '{
    '{KEY_ZERO,    5'd0,  5'd0,  1'b0, 1'b1, '{5'd0,  5'd0,  1'b0}},
    '{KEY_ZERO,    5'd31, 5'd31, 1'b0, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_ZERO,    5'd0,  5'd31, 1'b1, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_ZERO,    5'd0,  5'd5,  1'b0, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_CLASSIC, 5'd15, 5'd0,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd5,  5'd15, 1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd11, 5'd20, 1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd25, 5'd12, 1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd7,  5'd8,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd9,  5'd0,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd8,  5'd9,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd4,  5'd4,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd25, 5'd0,  1'b1, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd3,  5'd31, 1'b1, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd0,  5'd25, 1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd25, 5'd0,  1'b0, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{KEY_CLASSIC, 5'd26, 5'd0,  1'b0, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_CLASSIC, 5'd0,  5'd31, 1'b0, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_CLASSIC, 5'd31, 5'd30, 1'b1, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_ONES,    5'd31, 5'd31, 1'b0, 1'b1, '{5'd31, 5'd31, 1'b0}},
    '{KEY_ONES,    5'd0,  5'd31, 1'b0, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{KEY_ONES,    5'd31, 5'd0,  1'b1, 1'b1, '{5'd0,  5'd0,  1'b1}}
  };

  playfair_pair_encrypt_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // I and J count as the same letter
  function automatic logic letters_alike(letter_t a, letter_t b);
    return (a == b) || ({a, b} == {LETTER_I, LETTER_J}) || ({a, b} == {LETTER_J, LETTER_I});
  endfunction

  function automatic letter_t cell_at(int row, int col);
    return key_sq[((row % SQ_SIDE) * SQ_SIDE + (col % SQ_SIDE)) * CODE_W +: CODE_W];
  endfunction

  // Scan from the last cell down so the first match in row-major order wins
  function automatic logic find_letter(letter_t ltr, output int row, output int col);
    logic hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int p = SQ_CELLS - 1; p >= 0; p--) begin
      if (letters_alike(ltr, key_sq[p*CODE_W +: CODE_W])) begin
        hit = 1'b1;
        row = p / SQ_SIDE;
        col = p % SQ_SIDE;
      end
    end
    return hit;
  endfunction

  function automatic cipher_t encipher(letter_t first, letter_t second, logic pad);
    cipher_t res;
    letter_t partner;
    int      r1, c1, r2, c2;
    logic    f1, f2;
    partner = pad ? LETTER_X : second;
    f1 = find_letter(first, r1, c1);
    f2 = find_letter(partner, r2, c2);
    res = '0;
    if (!(f1 && f2)) begin
      res.not_found = 1'b1;
    end else if (r1 == r2) begin
      res.first  = cell_at(r1, c1 + 1);
      res.second = cell_at(r2, c2 + 1);
    end else if (c1 == c2) begin
      res.first  = cell_at(r1 + 1, c1);
      res.second = cell_at(r2 + 1, c2);
    end else begin
      res.first  = cell_at(r1, c2);
      res.second = cell_at(r2, c1);
    end
    return res;
  endfunction

  // Build a square: a shuffled alphabet, raw 5-bit codes, or a few letters repeated
  function automatic square_t random_square(square_mix_t mix);
    letter_t pool [26];
    letter_t tmp;
    square_t sq;
    int      j;
    for (int c = 0; c < 26; c++) pool[c] = letter_t'(c);
    for (int c = 25; c > 0; c--) begin
      j = $urandom_range(c);
      tmp = pool[c];
      pool[c] = pool[j];
      pool[j] = tmp;
    end
    for (int p = 0; p < SQ_CELLS; p++) begin
      case (mix)
        MIX_SCATTERED: sq[p*CODE_W +: CODE_W] = letter_t'($urandom_range(31));
        MIX_CROWDED:   sq[p*CODE_W +: CODE_W] = letter_t'($urandom_range(9));
        default:       sq[p*CODE_W +: CODE_W] = pool[p];
      endcase
    end
    return sq;
  endfunction

  // Mostly letters that sit in the square, sometimes I/J swapped, the rest raw codes
  function automatic letter_t pick_letter();
    letter_t ltr;
    int      pos;
    if ($urandom_range(99) < 75) begin
      pos = $urandom_range(SQ_CELLS - 1);
      ltr = key_sq[pos*CODE_W +: CODE_W];
      if ($urandom_range(99) < 30) begin
        if (ltr == LETTER_I) ltr = LETTER_J;
        else if (ltr == LETTER_J) ltr = LETTER_I;
      end
    end else begin
      ltr = letter_t'($urandom_range(31));
    end
    return ltr;
  endfunction

  // Write the selected key registers; the pipeline must be empty
  task automatic load_square(square_t sq, logic [2:0] mask);
    for (reg_idx_t idx = REG_ROWS_01; idx != REG_NONE; idx = idx.next()) begin
      if (mask[idx]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        case (idx)
          REG_ROWS_01: begin
            cfg_data <= sq[HALF_W-1:0];
            key_sq[HALF_W-1:0] = sq[HALF_W-1:0];
          end
          REG_ROWS_23: begin
            cfg_data <= sq[2*HALF_W-1:HALF_W];
            key_sq[2*HALF_W-1:HALF_W] = sq[2*HALF_W-1:HALF_W];
          end
          default: begin
            cfg_data <= {25'b0, sq[SQ_W-1:2*HALF_W]};
            key_sq[SQ_W-1:2*HALF_W] = sq[SQ_W-1:2*HALF_W];
          end
        endcase
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one pair, with an optional gap first, and log its expected cipher
  task automatic send_pair(letter_t first, letter_t second, logic pad, logic typed,
                           cipher_t typed_res);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, second, first};
    s_tuser  <= pad;
    do @(posedge clk); while (!s_tready);
    cipher_q.push_back(typed ? typed_res : encipher(first, second, pad));
  endtask

  // Hold off until every outstanding pair has come back
  task automatic drain_pairs();
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    key_pick_t   cur_key;
    square_t     sq;
    square_mix_t mix;
    logic [2:0]  mask;
    letter_t     first, second;
    logic        pad;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROWS_01;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, reloading the square whenever the row asks for another one
    cur_key = KEY_ZERO;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].key != cur_key) begin
        drain_pairs();
        case (dir_rows[i].key)
          KEY_ONES: sq = '1;
          KEY_CLASSIC: begin
            for (int p = 0; p < SQ_CELLS; p++) begin
              sq[p*CODE_W +: CODE_W] = letter_t'(classic_key[p] - "A");
            end
          end
          default: sq = '0;
        endcase
        load_square(sq, 3'b111);
        cur_key = dir_rows[i].key;
      end
      send_pair(dir_rows[i].first, dir_rows[i].second, dir_rows[i].pad,
                dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases: new square each time, idling mode changes every two phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pairs();
      case (ph / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      mix  = square_mix_t'(ph % 4);
      sq   = random_square(mix);
      mask = (mix == MIX_PARTIAL) ? 3'($urandom_range(7, 1)) : 3'b111;
      load_square(sq, mask);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        first  = pick_letter();
        second = pick_letter();
        pad    = ($urandom_range(99) < 15);
        send_pair(first, second, pad, 1'b0, '0);
      end
    end

    drain_pairs();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Compare each returned item with the oldest expected cipher, and stall at random
  always @(posedge clk) begin
    cipher_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_q.size() == 0) begin
        $error("result with no pair outstanding: tdata=%h tuser=%b", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = cipher_q.pop_front();
        if (m_tdata[4:0] !== want.first) begin
          $error("cipher_first: expected %0d, got %0d", want.first, m_tdata[4:0]);
          err_count++;
        end
        if (m_tdata[9:5] !== want.second) begin
          $error("cipher_second: expected %0d, got %0d", want.second, m_tdata[9:5]);
          err_count++;
        end
        if (m_tuser !== want.not_found) begin
          $error("not_found: expected %0b, got %0b", want.not_found, m_tuser);
          err_count++;
        end
      end
    end
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> sim.f
sv/pfe_pkg.sv
sv/pfe_locate.sv
sv/playfair_pair_encrypt_top.sv
sv/pfe_checker.sv
test/tb_playfair_pair_encrypt_top.sv
